FILE: src/erot_pkg.sv
// Shared constants, types and tables for the Euler XYZ point rotation block.
// No dependencies; used by erot_sine and euler_xyz_point_rotation.
package erot_pkg;

   // fraction bits of sines, cosines and matrix entries
   localparam int TRIG_FRAC_BITS = 15;
   // fraction bits of the quarter-wave polynomial arithmetic
   localparam int POLY_FRAC = 30;

   // angle units (hundredths of a degree)
   localparam int QUARTER_CDEG = 9000;
   localparam int TURN_CDEG = 36000;

   // register stages of one sine pipeline
   localparam int TRIG_LAT = 13;
   // width of the angle fed to a sine pipeline (sign extended, cosine offset added)
   localparam int ANGLE_W = 18;
   // width of a sine or cosine, signed, range -2^15..2^15
   localparam int TRIG_W = 17;

   typedef logic [TRIG_LAT-1:0] trig_en_type;
   typedef logic signed [TRIG_W-1:0] sine_type;

   // sin(pi/2*u) series coefficient magnitudes, Q1.30, orders 1,3,...,15
   localparam logic [30:0] SIN_COEF [8] = '{
      31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
      31'd172272, 31'd3864, 31'd61, 31'd1
   };

endpackage

FILE: src/erot_sine.sv
// Pipelined fixed-point sine of an angle in hundredths of a degree.
// Depends on erot_pkg; stage loads are driven by the top level's enables.
module erot_sine (
   input  logic                                  clock,
   input  erot_pkg::trig_en_type                 en,
   input  logic signed [erot_pkg::ANGLE_W-1:0]   angle,
   output erot_pkg::sine_type                    sine
);

   // floor(q * 2^30 / 9000) == (q * RECIP) >> RECIP_SHIFT for q in [0,9000]
   localparam logic [43:0] RECIP = 44'd16012798675096;
   localparam int RECIP_SHIFT = 27;
   localparam int SH = erot_pkg::POLY_FRAC - erot_pkg::TRIG_FRAC_BITS;

   logic [18:0] biased;
   logic [17:0] wrap;
   logic [15:0] rem_in, rem_ff;
   logic [13:0] quarter_in, quarter_ff;
   logic        neg_in;
   logic        neg_ff [1:11];
   logic [57:0] uprod;
   logic [30:0] u_ff [2:10];
   logic [61:0] vprod;
   logic [30:0] v_ff [3:9];
   logic [61:0] hprod [4:10];
   logic [30:0] horner_in [4:10];
   logic [30:0] p_ff [4:10];
   logic [61:0] sprod;
   logic [31:0] s_ff;
   logic [32:0] s_round;
   logic [15:0] mag;
   erot_pkg::sine_type sine_ff;

   // stage 1: reduce modulo one turn
   always_comb begin
      biased = 19'({angle[erot_pkg::ANGLE_W-1], angle}) + 19'd72000;
      wrap = biased[17:0];
      priority if (wrap >= 18'd144000) begin
         rem_in = 16'(wrap - 18'd144000);
      end else if (wrap >= 18'd108000) begin
         rem_in = 16'(wrap - 18'd108000);
      end else if (wrap >= 18'd72000) begin
         rem_in = 16'(wrap - 18'd72000);
      end else if (wrap >= 18'd36000) begin
         rem_in = 16'(wrap - 18'd36000);
      end else begin
         rem_in = wrap[15:0];
      end
   end

   // stage 2: quadrant fold onto the quarter wave
   always_comb begin
      priority if (rem_ff < 16'd9000) begin
         quarter_in = rem_ff[13:0];
         neg_in = 1'b0;
      end else if (rem_ff < 16'd18000) begin
         quarter_in = 14'(16'd18000 - rem_ff);
         neg_in = 1'b0;
      end else if (rem_ff < 16'd27000) begin
         quarter_in = 14'(rem_ff - 16'd18000);
         neg_in = 1'b1;
      end else begin
         quarter_in = 14'(16'd36000 - rem_ff);
         neg_in = 1'b1;
      end
   end

   // stage 3 and 4: scale to Q1.30, then square
   assign uprod = 58'(quarter_ff) * 58'(RECIP);
   assign vprod = 62'(u_ff[2]) * 62'(u_ff[2]);

   // stages 5 to 11: one Horner step each
   always_comb begin
      hprod[4] = 62'(erot_pkg::SIN_COEF[7]) * 62'(v_ff[3]);
      for (int s = 5; s <= 10; s++) begin
         hprod[s] = 62'(p_ff[s-1]) * 62'(v_ff[s-1]);
      end
      for (int s = 4; s <= 10; s++) begin
         horner_in[s] = 31'(32'(erot_pkg::SIN_COEF[10-s]) - hprod[s][61:30]);
      end
   end

   // stage 12 and 13: final product, round, clamp, sign
   assign sprod = 62'(u_ff[10]) * 62'(p_ff[10]);
   always_comb begin
      s_round = (33'(s_ff) + (33'd1 << (SH - 1))) >> SH;
      if (s_round > (33'd1 << erot_pkg::TRIG_FRAC_BITS)) begin
         mag = 16'(33'd1 << erot_pkg::TRIG_FRAC_BITS);
      end else begin
         mag = s_round[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) rem_ff <= rem_in;
      if (en[1]) begin
         quarter_ff <= quarter_in;
         neg_ff[1] <= neg_in;
      end
      for (int s = 2; s <= 11; s++) begin
         if (en[s]) neg_ff[s] <= neg_ff[s-1];
      end
      if (en[2]) u_ff[2] <= uprod[57:RECIP_SHIFT];
      for (int s = 3; s <= 10; s++) begin
         if (en[s]) u_ff[s] <= u_ff[s-1];
      end
      if (en[3]) v_ff[3] <= vprod[60:30];
      for (int s = 4; s <= 9; s++) begin
         if (en[s]) v_ff[s] <= v_ff[s-1];
      end
      for (int s = 4; s <= 10; s++) begin
         if (en[s]) p_ff[s] <= horner_in[s];
      end
      if (en[11]) s_ff <= sprod[61:30];
      if (en[12]) begin
         sine_ff <= neg_ff[11] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   end

   assign sine = sine_ff;

endmodule

FILE: src/euler_xyz_point_rotation.sv
// Euler XYZ point rotation, top level: stream ports, matrix and dot products.
// Depends on erot_pkg and erot_sine.
//
// Takes one transaction per clock while the pipeline has room, and returns
// p' = Rx*Ry*Rz*p for each one. The item passes 17 register stages: the six
// 13-stage sine/cosine pipelines (reduce, fold, scale, square, seven Horner
// steps, final product, round and sign), then two matrix stages, a product
// stage and the sum/saturate output register. Every stage carries a valid
// bit and only stalls while it holds data, so empty slots close up and new
// transactions are still taken while a result waits.
// Sines and cosines are Q1.15; coordinates keep their input format and clip
// to the 32-bit range, which is flagged in rsp_tuser.
module euler_xyz_point_rotation (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // angle_x_cdeg[16:0], angle_y_cdeg[33:17], angle_z_cdeg[50:34],
   // point_x[82:51], point_y[114:83], point_z[146:115], zero fill [151:147]
   input  logic [151:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // rotated_x[31:0], rotated_y[63:32], rotated_z[95:64]
   output logic [95:0]   rsp_tdata,
   // saturated[0]
   output logic [0:0]    rsp_tuser
);

   localparam int NSTG = erot_pkg::TRIG_LAT + 4;
   localparam int ST_M1 = erot_pkg::TRIG_LAT;
   localparam int ST_M2 = erot_pkg::TRIG_LAT + 1;
   localparam int ST_P1 = erot_pkg::TRIG_LAT + 2;
   localparam int ST_OUT = erot_pkg::TRIG_LAT + 3;

   function automatic logic signed [17:0] rnd_trig(input logic signed [34:0] x);
      logic signed [34:0] t;
      t = x + 35'sd16384;
      return 18'(t >>> erot_pkg::TRIG_FRAC_BITS);
   endfunction

   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] en;
   erot_pkg::trig_en_type trig_en;

   logic signed [16:0] ang [3];
   logic signed [erot_pkg::ANGLE_W-1:0] sin_ang [3];
   logic signed [erot_pkg::ANGLE_W-1:0] cos_ang [3];
   erot_pkg::sine_type sin_w [3];
   erot_pkg::sine_type cos_w [3];

   logic signed [31:0] pt_ff [0:ST_M2][3];

   logic signed [17:0] sxsy_ff, cxsy_ff, m00_ff, m01_ff, m02_ff, m12_ff, m22_ff;
   logic signed [33:0] cxsz_ff, cxcz_ff, sxsz_ff, sxcz_ff;
   logic signed [16:0] cz_ff, sz_ff;
   logic signed [17:0] m_ff [3][3];
   logic signed [49:0] mp_ff [3][3];
   logic signed [51:0] acc [3];
   logic signed [51:0] acc_rnd [3];
   logic signed [31:0] rot_in [3];
   logic signed [31:0] rot_ff [3];
   logic [2:0]         clip;
   logic               sat_ff;

   // stage enables: a stage loads when empty or when the next one moves
   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp_tready;
      for (int s = NSTG - 2; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end
   assign trig_en = en[erot_pkg::TRIG_LAT-1:0];
   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_tvalid;
         for (int s = 1; s < NSTG; s++) begin
            if (en[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   // sine and cosine pipelines, one pair per axis
   assign ang[0] = $signed(req_tdata[16:0]);
   assign ang[1] = $signed(req_tdata[33:17]);
   assign ang[2] = $signed(req_tdata[50:34]);

   for (genvar a = 0; a < 3; a++) begin : g_axis
      assign sin_ang[a] = erot_pkg::ANGLE_W'(ang[a]);
      assign cos_ang[a] = erot_pkg::ANGLE_W'(ang[a]) +
                          erot_pkg::ANGLE_W'(erot_pkg::QUARTER_CDEG);
      erot_sine u_sin (.clock(clock), .en(trig_en), .angle(sin_ang[a]), .sine(sin_w[a]));
      erot_sine u_cos (.clock(clock), .en(trig_en), .angle(cos_ang[a]), .sine(cos_w[a]));
   end

   // point delay line alongside the trig pipelines
   always_ff @(posedge clock) begin
      if (en[0]) begin
         pt_ff[0][0] <= $signed(req_tdata[82:51]);
         pt_ff[0][1] <= $signed(req_tdata[114:83]);
         pt_ff[0][2] <= $signed(req_tdata[146:115]);
      end
      for (int s = 1; s <= ST_M2; s++) begin
         if (en[s]) pt_ff[s] <= pt_ff[s-1];
      end
   end

   // matrix stage 1: pairwise products
   always_ff @(posedge clock) begin
      if (en[ST_M1]) begin
         sxsy_ff <= rnd_trig(35'(sin_w[0]) * 35'(sin_w[1]));
         cxsy_ff <= rnd_trig(35'(cos_w[0]) * 35'(sin_w[1]));
         m00_ff  <= rnd_trig(35'(cos_w[1]) * 35'(cos_w[2]));
         m01_ff  <= rnd_trig(35'(cos_w[1]) * 35'(sin_w[2]));
         m02_ff  <= -18'(sin_w[1]);
         m12_ff  <= rnd_trig(35'(sin_w[0]) * 35'(cos_w[1]));
         m22_ff  <= rnd_trig(35'(cos_w[0]) * 35'(cos_w[1]));
         cxsz_ff <= 34'(cos_w[0]) * 34'(sin_w[2]);
         cxcz_ff <= 34'(cos_w[0]) * 34'(cos_w[2]);
         sxsz_ff <= 34'(sin_w[0]) * 34'(sin_w[2]);
         sxcz_ff <= 34'(sin_w[0]) * 34'(cos_w[2]);
         cz_ff   <= cos_w[2];
         sz_ff   <= sin_w[2];
      end
   end

   // matrix stage 2: mixed entries
   always_ff @(posedge clock) begin
      if (en[ST_M2]) begin
         m_ff[0][0] <= m00_ff;
         m_ff[0][1] <= m01_ff;
         m_ff[0][2] <= m02_ff;
         m_ff[1][0] <= rnd_trig(35'(sxsy_ff) * 35'(cz_ff) - 35'(cxsz_ff));
         m_ff[1][1] <= rnd_trig(35'(sxsy_ff) * 35'(sz_ff) + 35'(cxcz_ff));
         m_ff[1][2] <= m12_ff;
         m_ff[2][0] <= rnd_trig(35'(cxsy_ff) * 35'(cz_ff) + 35'(sxsz_ff));
         m_ff[2][1] <= rnd_trig(35'(cxsy_ff) * 35'(sz_ff) - 35'(sxcz_ff));
         m_ff[2][2] <= m22_ff;
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (en[ST_P1]) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               mp_ff[i][k] <= 50'(m_ff[i][k]) * 50'(pt_ff[ST_M2][k]);
            end
         end
      end
   end

   // sum, round and saturate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = 52'(mp_ff[i][0]) + 52'(mp_ff[i][1]) + 52'(mp_ff[i][2]);
         acc_rnd[i] = (acc[i] + 52'sd16384) >>> erot_pkg::TRIG_FRAC_BITS;
         if (acc_rnd[i] > 52'sd2147483647) begin
            rot_in[i] = 32'sh7fffffff;
            clip[i] = 1'b1;
         end else if (acc_rnd[i] < -52'sd2147483648) begin
            rot_in[i] = 32'sh80000000;
            clip[i] = 1'b1;
         end else begin
            rot_in[i] = 32'(acc_rnd[i]);
            clip[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         rot_ff <= rot_in;
         sat_ff <= |clip;
      end
   end

   assign rsp_tvalid = v_ff[ST_OUT];
   assign rsp_tdata = {rot_ff[2], rot_ff[1], rot_ff[0]};
   assign rsp_tuser = sat_ff;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // input is held off only when every stage is full and the output stalls
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready && (&v_ff)))
      else $error("input stalled with room in the pipeline");

   // the saturation flag comes with a coordinate at a bound
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (rot_ff[0] == 32'sh7fffffff || rot_ff[0] == 32'sh80000000 ||
          rot_ff[1] == 32'sh7fffffff || rot_ff[1] == 32'sh80000000 ||
          rot_ff[2] == 32'sh7fffffff || rot_ff[2] == 32'sh80000000))
      else $error("saturation flag without clipped coordinate");

endmodule

FILE: tb/sv/euler_xyz_point_rotation_tb.sv
// Self-checking testbench for euler_xyz_point_rotation: streams angle/point
// transactions, predicts each rotated point and compares. Depends on erot_pkg.
module euler_xyz_point_rotation_tb;

   typedef struct packed {
      logic signed [31:0] pz;
      logic signed [31:0] py;
      logic signed [31:0] px;
      logic signed [16:0] az;
      logic signed [16:0] ay;
      logic signed [16:0] ax;
   } point_req_type;

   typedef struct packed {
      logic        sat;
      logic [31:0] rz;
      logic [31:0] ry;
      logic [31:0] rx;
   } rotated_type;

   localparam longint CYCLE_LIMIT = 200000;
   localparam longint SIN_C [8] = '{1686629713, 693598668, 85569306, 5026995,
                                    172272, 3864, 61, 1};

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [95:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         accepted_q = 0;

   point_req_type pending_reqs[$];
   rotated_type   expected_points[$];
   int   errors = 0;
   int   points_checked = 0;
   int   sat_seen = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   bit   quiet = 0;
   bit   hold_send = 0;
   longint cycles = 0;

   euler_xyz_point_rotation dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // fixed-point helpers
   function automatic longint rnd_shr(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint quarter_sin(longint q);
      longint u, v, p, s;
      u = (q << erot_pkg::POLY_FRAC) / erot_pkg::QUARTER_CDEG;
      v = (u * u) >> erot_pkg::POLY_FRAC;
      p = SIN_C[7];
      for (int k = 6; k >= 0; k--) p = SIN_C[k] - ((p * v) >> erot_pkg::POLY_FRAC);
      s = (u * p) >> erot_pkg::POLY_FRAC;
      s = (s + (longint'(1) << (erot_pkg::POLY_FRAC - erot_pkg::TRIG_FRAC_BITS - 1)))
          >> (erot_pkg::POLY_FRAC - erot_pkg::TRIG_FRAC_BITS);
      if (s > (longint'(1) << erot_pkg::TRIG_FRAC_BITS))
         s = longint'(1) << erot_pkg::TRIG_FRAC_BITS;
      return s;
   endfunction

   function automatic longint sin_cdeg(longint r);
      longint q, f;
      r = r % erot_pkg::TURN_CDEG;
      if (r < 0) r += erot_pkg::TURN_CDEG;
      q = r / erot_pkg::QUARTER_CDEG;
      f = r % erot_pkg::QUARTER_CDEG;
      unique case (q)
         0: return quarter_sin(f);
         1: return quarter_sin(erot_pkg::QUARTER_CDEG - f);
         2: return -quarter_sin(f);
         default: return -quarter_sin(erot_pkg::QUARTER_CDEG - f);
      endcase
   endfunction

   // rotated point for one request: M = Rx*Ry*Rz, then M*p with saturation
   function automatic rotated_type rotate_point(point_req_type t);
      longint sx, cx, sy, cy, sz, cz, sxsy, cxsy, acc, r;
      longint m [3][3];
      longint p [3];
      logic [31:0] o [3];
      rotated_type res;
      sx = sin_cdeg(t.ax); cx = sin_cdeg(longint'(t.ax) + erot_pkg::QUARTER_CDEG);
      sy = sin_cdeg(t.ay); cy = sin_cdeg(longint'(t.ay) + erot_pkg::QUARTER_CDEG);
      sz = sin_cdeg(t.az); cz = sin_cdeg(longint'(t.az) + erot_pkg::QUARTER_CDEG);
      p[0] = t.px; p[1] = t.py; p[2] = t.pz;
      sxsy = rnd_shr(sx * sy, erot_pkg::TRIG_FRAC_BITS);
      cxsy = rnd_shr(cx * sy, erot_pkg::TRIG_FRAC_BITS);
      m[0][0] = rnd_shr(cy * cz, erot_pkg::TRIG_FRAC_BITS);
      m[0][1] = rnd_shr(cy * sz, erot_pkg::TRIG_FRAC_BITS);
      m[0][2] = -sy;
      m[1][0] = rnd_shr(-cx * sz + sxsy * cz, erot_pkg::TRIG_FRAC_BITS);
      m[1][1] = rnd_shr(cx * cz + sxsy * sz, erot_pkg::TRIG_FRAC_BITS);
      m[1][2] = rnd_shr(sx * cy, erot_pkg::TRIG_FRAC_BITS);
      m[2][0] = rnd_shr(sx * sz + cxsy * cz, erot_pkg::TRIG_FRAC_BITS);
      m[2][1] = rnd_shr(-sx * cz + cxsy * sz, erot_pkg::TRIG_FRAC_BITS);
      m[2][2] = rnd_shr(cx * cy, erot_pkg::TRIG_FRAC_BITS);
      res.sat = 0;
      for (int i = 0; i < 3; i++) begin
         acc = m[i][0] * p[0] + m[i][1] * p[1] + m[i][2] * p[2];
         r = rnd_shr(acc, erot_pkg::TRIG_FRAC_BITS);
         if (r > 64'sd2147483647) begin
            r = 64'sd2147483647; res.sat = 1;
         end else if (r < -64'sd2147483648) begin
            r = -64'sd2147483648; res.sat = 1;
         end
         o[i] = r[31:0];
      end
      res.rx = o[0]; res.ry = o[1]; res.rz = o[2];
      return res;
   endfunction

   function automatic logic [31:0] rand_coord();
      unique case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 65535) - 32768;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [16:0] rand_angle();
      unique case ($urandom_range(0, 7))
         0: return 17'd0;
         1: return 17'(int'($urandom_range(0, 8)) * 9000 - 36000);
         2: return 17'($urandom());  // full 17-bit range, wraps
         default: return 17'(int'($urandom_range(0, 72000)) - 36000);
      endcase
   endfunction

   function automatic point_req_type mk_req(int ax, int ay, int az,
                                            logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z);
      point_req_type t;
      t.ax = 17'(ax); t.ay = 17'(ay); t.az = 17'(az);
      t.px = x; t.py = y; t.pz = z;
      return t;
   endfunction

   // stimulus
   initial begin
      // directed: identity, quadrant edges, wrap, extremes, saturation
      pending_reqs.push_back(mk_req(0, 0, 0, 32'h00010000, 32'hfffe0000, 32'h7fffffff));
      pending_reqs.push_back(mk_req(0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h0));
      pending_reqs.push_back(mk_req(9000, 0, 0, 32'h00010000, 32'h00020000, 32'h00030000));
      pending_reqs.push_back(mk_req(0, 9000, 0, 32'h00010000, 32'h00020000, 32'h00030000));
      pending_reqs.push_back(mk_req(0, 0, 9000, 32'h00010000, 32'h00020000, 32'h00030000));
      pending_reqs.push_back(mk_req(18000, 27000, -9000, 32'h00010000, 32'h1, 32'hffffffff));
      pending_reqs.push_back(mk_req(36000, -36000, 36000, 32'h12345678, 32'h9abcdef0, 32'h1));
      pending_reqs.push_back(mk_req(-65536, 65535, -1, 32'h00010000, 32'h00010000, 32'h00010000));
      pending_reqs.push_back(mk_req(4500, 4500, 4500, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      pending_reqs.push_back(mk_req(4500, 4500, 4500, 32'h80000000, 32'h80000000, 32'h80000000));
      pending_reqs.push_back(mk_req(-4500, 13500, 31500, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
      pending_reqs.push_back(mk_req(1, 8999, 9001, 32'h0, 32'h0, 32'h0));
      pending_reqs.push_back(mk_req(-36000, 35999, -35999, 32'hffffffff, 32'h1, 32'h55555555));
      pending_reqs.push_back(mk_req(17999, 18001, 26999, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa));
      for (int i = 0; i < 640; i++)
         pending_reqs.push_back(mk_req(rand_angle(), rand_angle(), rand_angle(),
                                       rand_coord(), rand_coord(), rand_coord()));
      repeat (2) @(posedge clock);
      @(negedge clock) reset = 0;
      // pause the sender midway until the block drains
      wait (pending_reqs.size() < 330);
      @(negedge clock) hold_send = 1;
      wait (expected_points.size() == 0);
      @(negedge clock) hold_send = 0;
      wait (pending_reqs.size() < 100);
      quiet = 1;
   end

   // driver: request side and response stalls, changes on falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || accepted_q) begin
            if (!hold_send && send_gap == 0 && pending_reqs.size() > 0) begin
               req_tdata <= {5'b0, pending_reqs.pop_front()};
               req_tvalid <= 1;
               if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
            end else begin
               req_tvalid <= 0;
               if (send_gap > 0) send_gap--;
            end
         end
         // response side stalls
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_tready <= 0;
         end else
            rsp_tready <= 1;
      end
   end

   // monitor: both channels sampled at rising edge
   always @(posedge clock) begin
      rotated_type got, want;
      accepted_q <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         cycles++;
         if (req_tvalid && req_tready) begin
            expected_points.push_back(rotate_point(point_req_type'(req_tdata[146:0])));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (expected_points.size() == 0) begin
               $error("result with nothing expected: %h", got);
               errors++;
            end else begin
               want = expected_points.pop_front();
               points_checked++;
               if (want.sat) sat_seen++;
               if (got.rx !== want.rx) begin
                  $error("rotated_x expected %h actual %h", want.rx, got.rx); errors++;
               end
               if (got.ry !== want.ry) begin
                  $error("rotated_y expected %h actual %h", want.ry, got.ry); errors++;
               end
               if (got.rz !== want.rz) begin
                  $error("rotated_z expected %h actual %h", want.rz, got.rz); errors++;
               end
               if (got.sat !== want.sat) begin
                  $error("saturated expected %b actual %b", want.sat, got.sat); errors++;
               end
            end
         end
      end
   end

   // end of run and watchdog
   initial begin
      wait (!reset);
      fork
         begin
            wait (pending_reqs.size() == 0 && !req_tvalid);
            wait (expected_points.size() == 0);
            repeat (40) @(posedge clock);
         end
         wait (cycles >= CYCLE_LIMIT);
      join_any
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, expected_points.size());
         $display("** euler_xyz_point_rotation: FAILED **");
      end else begin
         $display("checked %0d rotated points (%0d saturating), with random",
                  points_checked, sat_seen);
         $display("stalls on both sides, a full drain pause and a back-to-back tail");
         if (errors == 0 && expected_points.size() == 0)
            $display("** euler_xyz_point_rotation: PASSED **");
         else
            $display("** euler_xyz_point_rotation: FAILED **");
      end
      $finish;
   end
endmodule

FILE: filelist.f
src/erot_pkg.sv
src/erot_sine.sv
src/euler_xyz_point_rotation.sv
tb/sv/euler_xyz_point_rotation_tb.sv
